// ===== hw/rtl/isotp_pkg.sv =====
// shared types and constants for the iso-tp transmit segmenter
`timescale 1ns / 1ps
package isotp_pkg;
	localparam int unsigned MAX_PAYLOAD_DEF = 4096;

	typedef enum logic [1:0] {
		OP_LOAD = 2'd0,
		OP_SEND = 2'd1,
		OP_FLOW = 2'd2,
		OP_RCPT = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_REFUSED = 2'd1,
		ST_NOCONS  = 2'd2,
		ST_OVERFL  = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		CFG_ID   = 3'd0,
		CFG_29   = 3'd1,
		CFG_EXT  = 3'd2,
		CFG_ADDR = 3'd3,
		CFG_PAD  = 3'd4
	} cfg_idx_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_DONE
	} fsm_t;

	localparam logic [3:0] PCI_FF   = 4'h1;
	localparam logic [3:0] PCI_CF   = 4'h2;
	localparam logic [3:0] PCI_FC   = 4'h3;
	localparam logic [7:0] PAD_BYTE = 8'h00;
endpackage

// ===== hw/rtl/isotp_tx_segmenter.sv =====
// iso-tp transmit segmenter top level: payload store, frame builder and receipt matcher
`timescale 1ns / 1ps
// Each request is taken when start is high and busy is low, and gives exactly one
// result, shown for one cycle with done high; the receiver cannot stall it. A
// send request walks the byte-wide payload memory, which has one read port with
// a registered read, fetching the frame's payload bytes one at a time before
// done; other requests go straight from the read state to done. busy stays high
// from acceptance until done.
// Configuration writes are always ready and should be made only while idle.
// A message is loaded one byte per load request; the byte marked last closes it
// and latches the addressing and padding settings for that message.
module isotp_tx_segmenter import isotp_pkg::*; #(
	parameter int unsigned MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  op,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	input  logic        link_ready,
	input  logic [7:0]  fc_block_size,
	input  logic        fc_send_all,
	input  logic [31:0] rx_identifier,
	input  logic        rx_is_29bit,
	input  logic [3:0]  rx_length,
	input  logic [63:0] rx_payload,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	output logic        done,
	output logic [1:0]  status,
	output logic [63:0] frame_bytes,
	output logic [3:0]  frame_length,
	output logic [9:0]  frame_number,
	output logic        tx_confirm,
	output logic        message_finished,
	output logic        tx_ready
);
	localparam int AW = $clog2(MAX_PAYLOAD);
	localparam logic [12:0] CNT_LIMIT = 13'(MAX_PAYLOAD - 1);

	// configuration registers
	logic [31:0] can_id_q;
	logic        id29_q, ext_q, pad_q;
	logic [7:0]  addr_q;

	// message state
	logic [12:0] count_q, roff_q;
	logic [9:0]  fdone_q, ftotal_q;
	logic        inflight_q, unlim_q, ovf_q;
	logic [7:0]  budget_q;
	logic [63:0] lframe_q;
	logic [3:0]  llen_q;
	logic        mext_q, mpad_q;
	logic [7:0]  maddr_q;

	// request registers
	fsm_t        state_q, state_d;
	op_t         op_q;
	logic [7:0]  dbyte_q, fcbs_q;
	logic        lastb_q, link_q, fcall_q, r29_q;
	logic [31:0] rid_q;
	logic [3:0]  rlen_q;
	logic [63:0] rpl_q;

	// frame builder
	logic [63:0] fb_q;
	logic [3:0]  n_q;          // next byte position in frame
	logic [2:0]  left_q;       // payload bytes still to fetch
	logic [2:0]  used_q;
	logic [12:0] raddr_q;
	logic        rpend_q;      // read issued last cycle

	// payload memory, one write and one read port
	logic [7:0] mem [MAX_PAYLOAD];
	logic [7:0] rdata_q;
	logic       we;
	logic [AW-1:0] waddr;

	assign cfg_ready = 1'b1;
	assign busy = (state_q != S_IDLE);

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= dbyte_q;
		rdata_q <= mem[raddr_q[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			can_id_q <= '0; id29_q <= 1'b0; ext_q <= 1'b0; addr_q <= '0; pad_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_idx_t'(cfg_index))
				CFG_ID:   can_id_q <= cfg_data;
				CFG_29:   id29_q <= cfg_data[0];
				CFG_EXT:  ext_q <= cfg_data[0];
				CFG_ADDR: addr_q <= cfg_data[7:0];
				CFG_PAD:  pad_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// frame count for a closing message
	logic [12:0] ld_count, cnt_after;
	logic        ld_drop;
	logic [9:0]  nframes;
	logic [12:0] cf_rem;
	logic [3:0]  cf_size;
	logic [12:0] cf_num;
	logic [25:0] cf_prod;
	always_comb begin
		ld_drop = (ftotal_q != 10'd0);
		ld_count = ld_drop ? 13'd0 : count_q;
		cnt_after = (ld_count >= CNT_LIMIT) ? ld_count : ld_count + 13'd1;
		cf_size = ext_q ? 4'd6 : 4'd7;
		cf_rem = cnt_after - 13'(cf_size) + 13'd1; // bytes beyond first frame
		// ceiling divide by the frame size: reciprocal multiply, exact below 4097
		cf_num = ext_q ? cf_rem + 13'd5 : cf_rem + 13'd6;
		cf_prod = 26'(cf_num) * (ext_q ? 26'd2731 : 26'd2341);
		nframes = 10'd1;
		if (cnt_after > 13'(cf_size))
			nframes = 10'd1 + cf_prod[23:14];
	end

	// send checks
	logic        send_ok;
	logic        is_sf, is_ff;
	logic [3:0]  pfx;
	always_comb begin
		send_ok = !(fdone_q >= ftotal_q) &&
			!(budget_q == 8'd0 && !unlim_q && fdone_q != 10'd0);
		is_sf = (ftotal_q == 10'd1);
		is_ff = !is_sf && (fdone_q == 10'd0);
		pfx = mext_q ? 4'd1 : 4'd0;
	end

	// receipt match
	logic [63:0] rmask;
	logic        rcpt_fc, rcpt_ok;
	logic [7:0]  pci_byte;
	always_comb begin
		rmask = (rlen_q >= 4'd8) ? '1 : ((64'd1 << {rlen_q[2:0], 3'b000}) - 64'd1);
		pci_byte = mext_q ? rpl_q[15:8] : rpl_q[7:0];
		rcpt_fc = (rlen_q >= pfx + 4'd1) && (pci_byte[7:4] == PCI_FC);
		rcpt_ok = inflight_q && !rcpt_fc && rid_q == can_id_q && r29_q == id29_q &&
			rlen_q == llen_q && (rpl_q & rmask) == lframe_q;
	end

	always_comb begin
		we = (state_q == S_READ) && op_q == OP_LOAD && !(ld_count >= CNT_LIMIT);
		waddr = ld_count[AW-1:0];
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: if (start) state_d = S_READ;
			S_READ: begin
				if (op_q != OP_SEND || !(send_ok && link_q) ||
						(left_q == 3'd0 && !rpend_q))
					state_d = S_DONE;
			end
			S_DONE: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			op_q <= op_t'(op); dbyte_q <= data_byte; lastb_q <= last_byte;
			link_q <= link_ready; fcbs_q <= fc_block_size; fcall_q <= fc_send_all;
			rid_q <= rx_identifier; r29_q <= rx_is_29bit; rlen_q <= rx_length;
			rpl_q <= rx_payload;
		end
	end

	// main datapath and result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0; roff_q <= '0; fdone_q <= '0; ftotal_q <= '0;
			inflight_q <= 1'b0; unlim_q <= 1'b0; ovf_q <= 1'b0; budget_q <= '0;
			lframe_q <= '0; llen_q <= '0; mext_q <= 1'b0; mpad_q <= 1'b0; maddr_q <= '0;
			done <= 1'b0; status <= ST_OK; frame_bytes <= '0; frame_length <= '0;
			frame_number <= '0; tx_confirm <= 1'b0;
			fb_q <= '0; n_q <= '0; left_q <= '0; used_q <= '0; raddr_q <= '0;
			rpend_q <= 1'b0;
		end else begin
			done <= 1'b0;
			if (state_q == S_IDLE && start) begin
				// prime the frame builder for a possible send
				fb_q <= '0; n_q <= '0; used_q <= '0; rpend_q <= 1'b0;
				raddr_q <= is_ff || is_sf ? 13'd0 : roff_q;
				if (is_sf) left_q <= count_q[2:0] > 3'(3'd7 - 3'(pfx)) ?
					3'(3'd7 - 3'(pfx)) : count_q[2:0];
				else if (is_ff) left_q <= 3'(3'd6 - 3'(pfx));
				else left_q <= ((count_q - roff_q) > 13'(7 - pfx)) ?
					3'(3'd7 - 3'(pfx)) : 3'(count_q - roff_q);
				// header bytes
				if (is_sf) begin
					if (mext_q) fb_q[15:0] <= {count_q[7:0], maddr_q};
					else fb_q[7:0] <= count_q[7:0];
					n_q <= pfx + 4'd1;
				end else if (is_ff) begin
					if (mext_q) fb_q[23:0] <= {count_q[7:0], PCI_FF, count_q[11:8], maddr_q};
					else fb_q[15:0] <= {count_q[7:0], PCI_FF, count_q[11:8]};
					n_q <= pfx + 4'd2;
				end else begin
					if (mext_q) fb_q[15:0] <= {PCI_CF, fdone_q[3:0], maddr_q};
					else fb_q[7:0] <= {PCI_CF, fdone_q[3:0]};
					n_q <= pfx + 4'd1;
				end
			end else if (state_q == S_READ) begin
				if (op_q == OP_SEND && send_ok && link_q) begin
					// one payload byte per cycle through the memory
					if (rpend_q) begin
						fb_q[{n_q[2:0], 3'b000} +: 8] <= rdata_q;
						n_q <= n_q + 4'd1;
						used_q <= used_q + 3'd1;
					end
					rpend_q <= (left_q != 3'd0);
					if (left_q != 3'd0) begin
						left_q <= left_q - 3'd1;
						raddr_q <= raddr_q + 13'd1;
					end
				end
				if (state_d == S_DONE) begin
					done <= 1'b1;
					status <= ST_OK; frame_bytes <= '0; frame_length <= '0;
					frame_number <= '0; tx_confirm <= 1'b0;
				end
				case (op_q)
					OP_LOAD: begin
						if (ld_drop) begin
							fdone_q <= '0; ftotal_q <= '0; roff_q <= '0; inflight_q <= 1'b0;
							budget_q <= '0; unlim_q <= 1'b0; lframe_q <= '0; llen_q <= '0;
						end
						count_q <= cnt_after;
						if (ld_count >= CNT_LIMIT) status <= ST_OVERFL;
						ovf_q <= (ld_drop ? 1'b0 : ovf_q) | (ld_count >= CNT_LIMIT);
						if (lastb_q) begin
							if ((ld_drop ? 1'b0 : ovf_q) || ld_count >= CNT_LIMIT) begin
								status <= ST_OVERFL;
								count_q <= '0; fdone_q <= '0; ftotal_q <= '0; roff_q <= '0;
								inflight_q <= 1'b0; budget_q <= '0; unlim_q <= 1'b0;
								lframe_q <= '0; llen_q <= '0; ovf_q <= 1'b0;
							end else begin
								mext_q <= ext_q; maddr_q <= addr_q; mpad_q <= pad_q;
								ftotal_q <= nframes;
							end
						end
					end
					OP_SEND: begin
						if (!(send_ok && link_q)) status <= ST_REFUSED;
						else if (state_d == S_DONE) begin
							// frame complete: commit it
							frame_bytes <= fb_q;
							frame_length <= ((is_sf || !is_ff) && mpad_q) ? 4'd8 : n_q;
							frame_number <= fdone_q;
							lframe_q <= fb_q;
							llen_q <= ((is_sf || !is_ff) && mpad_q) ? 4'd8 : n_q;
							if (budget_q != 8'd0 && !unlim_q) budget_q <= budget_q - 8'd1;
							roff_q <= is_sf ? count_q : roff_q + 13'(used_q);
							inflight_q <= 1'b1;
							fdone_q <= fdone_q + 10'd1;
						end
					end
					OP_FLOW: begin
						budget_q <= fcbs_q; unlim_q <= fcall_q;
					end
					OP_RCPT: begin
						status <= ST_NOCONS;
						if (rcpt_ok) begin
							status <= ST_OK; inflight_q <= 1'b0;
							tx_confirm <= (fdone_q == ftotal_q);
						end
					end
					default: ;
				endcase
			end
		end
	end

	// flags follow the state after the request's update
	always_comb begin
		message_finished = (fdone_q == ftotal_q) && !inflight_q;
		tx_ready = (budget_q != 8'd0) || unlim_q || (fdone_q == 10'd0);
	end

	assert property (@(posedge clk) disable iff (!arst_n) done |-> busy)
		else $error("result without request");
	assert property (@(posedge clk) disable iff (!arst_n) (start && !busy) |=> busy)
		else $error("request not taken");
	assert property (@(posedge clk) disable iff (!arst_n) fdone_q <= ftotal_q)
		else $error("frames past total");
	assert property (@(posedge clk) disable iff (!arst_n) done |=> !done)
		else $error("result held two cycles");
endmodule

// ===== bench/tb.sv =====
// self-checking testbench for the iso-tp transmit segmenter
`timescale 1ns / 1ps
module tb;
	import isotp_pkg::*;

	localparam int unsigned STORE_DEPTH = MAX_PAYLOAD_DEF;
	// longest quiet stretch: a request gap, a send and the idle wait before a write
	localparam int WATCHDOG_LIMIT = 2000;
	// length of the message sent back to back at the end
	localparam int LONG_MSG = 120;

	// one request as the driver presents it, plus the idle cycles in front of it
	typedef struct {
		op_t         op;
		logic [7:0]  data_byte;
		logic        last_byte;
		logic        link_ready;
		logic [7:0]  fc_bs;
		logic        fc_all;
		logic [31:0] rid;
		logic        r29;
		logic [3:0]  rlen;
		logic [63:0] rpl;
		int          gap;
	} seg_req_t;

	// one result, laid out in port order
	typedef struct packed {
		status_t     status;
		logic [63:0] fbytes;
		logic [3:0]  flen;
		logic [9:0]  fnum;
		logic        ind;
		logic        fin;
		logic        rdy;
	} seg_res_t;

	typedef struct packed {
		logic [31:0] id;
		logic        is29;
		logic        ext;
		logic [7:0]  addr;
		logic        pad;
	} seg_cfg_t;

	// segmenter state as the bench tracks it
	typedef struct {
		logic [7:0]  store [STORE_DEPTH];
		logic [12:0] count;
		logic [9:0]  done_cnt;
		logic [9:0]  total;
		logic [12:0] rd_off;
		logic        in_flight;
		logic [7:0]  budget;
		logic        unlimited;
		logic [63:0] last_frame;
		logic [3:0]  last_len;
		logic        ovf;
		logic        m_ext;
		logic [7:0]  m_addr;
		logic        m_pad;
	} seg_state_t;

	// dut signals, all known from time zero
	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [1:0]  op = OP_LOAD;
	logic [7:0]  data_byte = '0;
	logic        last_byte = 1'b0;
	logic        link_ready = 1'b0;
	logic [7:0]  fc_block_size = '0;
	logic        fc_send_all = 1'b0;
	logic [31:0] rx_identifier = '0;
	logic        rx_is_29bit = 1'b0;
	logic [3:0]  rx_length = '0;
	logic [63:0] rx_payload = '0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = CFG_ID;
	logic [31:0] cfg_data = '0;
	logic        done;
	logic [1:0]  status;
	logic [63:0] frame_bytes;
	logic [3:0]  frame_length;
	logic [9:0]  frame_number;
	logic        tx_confirm;
	logic        message_finished;
	logic        tx_ready;

	// pending requests, and the results they are predicted to give
	seg_req_t   req_q [$];
	seg_res_t   frame_exp_q [$];
	seg_req_t   cur_req;
	// one copy of the state runs ahead for the stimulus, the other follows acceptance
	seg_state_t gen_st;
	seg_state_t dut_st;
	seg_cfg_t   cfg_cur = '0;
	int         hold_cnt = 0;
	int         quiet_cnt = 0;
	int         burst_left = 0;
	bit         no_gaps = 1'b0;
	int         gen_items = 0;
	int         n_errors = 0;
	int         n_results = 0;
	int         n_frames = 0;
	int         n_ind = 0;

	isotp_tx_segmenter DUT (.*);

	initial begin
		forever #4 clk = ~clk;
	end

	// ---------------------------------------------------------------- predictor

	function automatic void drop_msg(inout seg_state_t s);
		s.count = '0;
		s.done_cnt = '0;
		s.total = '0;
		s.rd_off = '0;
		s.in_flight = 1'b0;
		s.budget = '0;
		s.unlimited = 1'b0;
		s.last_frame = '0;
		s.last_len = '0;
		s.ovf = 1'b0;
	endfunction

	function automatic void clear_state(inout seg_state_t s);
		foreach (s.store[i]) s.store[i] = '0;
		drop_msg(s);
		s.m_ext = 1'b0;
		s.m_addr = '0;
		s.m_pad = 1'b0;
	endfunction

	// single frame if it fits, else first frame plus consecutive frames
	function automatic logic [9:0] frame_count(input int len, input int p);
		if (len <= 7 - p) return 10'd1;
		return 10'(1 + (len - (6 - p) + (7 - p) - 1) / (7 - p));
	endfunction

	function automatic seg_res_t seg_step(inout seg_state_t s, input seg_req_t r,
			input seg_cfg_t c);
		seg_res_t    res;
		logic [7:0]  b [8];
		int          n;
		int          used;
		int          p;
		int          chunk;
		int          i;
		logic [63:0] mask;
		logic        is_fc;
		res = '0;
		res.status = ST_OK;
		case (r.op)
			OP_LOAD: begin
				// a load after a complete message starts a new one
				if (s.total != 0) drop_msg(s);
				if (s.count >= STORE_DEPTH - 1) begin
					s.ovf = 1'b1;
					res.status = ST_OVERFL;
				end else begin
					s.store[s.count] = r.data_byte;
					s.count++;
				end
				if (r.last_byte) begin
					if (s.ovf) begin
						drop_msg(s);
						res.status = ST_OVERFL;
					end else begin
						s.m_ext = c.ext;
						s.m_addr = c.addr;
						s.m_pad = c.pad;
						s.total = frame_count(s.count, c.ext);
					end
				end
			end
			OP_SEND: begin
				if (s.done_cnt >= s.total || (s.budget == 0 && !s.unlimited && s.done_cnt > 0)
						|| !r.link_ready) begin
					res.status = ST_REFUSED;
				end else begin
					for (i = 0; i < 8; i++) b[i] = PAD_BYTE;
					n = 0;
					used = 0;
					p = s.m_ext;
					if (p != 0) begin
						b[n] = s.m_addr;
						n++;
					end
					if (s.total == 1) begin
						b[n] = s.count[7:0];
						n++;
						for (i = 0; i < s.count && n < 8; i++) begin
							b[n] = s.store[i];
							n++;
						end
						used = s.count;
						if (s.m_pad) n = 8;
					end else if (s.done_cnt == 0) begin
						b[n] = {PCI_FF, s.count[11:8]};
						n++;
						b[n] = s.count[7:0];
						n++;
						chunk = 6 - p;
						for (i = 0; i < chunk && n < 8; i++) begin
							b[n] = s.store[i];
							n++;
						end
						used = chunk;
					end else begin
						b[n] = {PCI_CF, s.done_cnt[3:0]};
						n++;
						chunk = 7 - p;
						for (i = 0; i < chunk && s.rd_off + i < s.count && n < 8; i++) begin
							b[n] = s.store[s.rd_off + i];
							n++;
						end
						used = i;
						if (s.m_pad) n = 8;
					end
					for (i = 0; i < n; i++) res.fbytes[8*i +: 8] = b[i];
					res.flen = 4'(n);
					res.fnum = s.done_cnt;
					if (s.budget > 0 && !s.unlimited) s.budget--;
					s.rd_off = 13'(s.rd_off + used);
					s.last_frame = res.fbytes;
					s.last_len = 4'(n);
					s.in_flight = 1'b1;
					s.done_cnt++;
				end
			end
			OP_FLOW: begin
				s.budget = r.fc_bs;
				s.unlimited = r.fc_all;
			end
			default: begin
				// receipt: must echo the last frame and must not look like flow control
				p = s.m_ext;
				mask = (r.rlen >= 8) ? '1 : ((64'd1 << (8 * r.rlen)) - 64'd1);
				is_fc = (r.rlen >= p + 1) && (((r.rpl >> (8 * p)) & 64'hF0) == {PCI_FC, 4'h0});
				res.status = ST_NOCONS;
				if (s.in_flight && !is_fc && r.rid == c.id && r.r29 == c.is29
						&& r.rlen == s.last_len && (r.rpl & mask) == s.last_frame) begin
					s.in_flight = 1'b0;
					res.status = ST_OK;
					if (s.done_cnt == s.total) res.ind = 1'b1;
				end
			end
		endcase
		res.fin = (s.done_cnt == s.total) && !s.in_flight;
		res.rdy = (s.budget > 0) || s.unlimited || (s.done_cnt == 0);
		return res;
	endfunction

	// ---------------------------------------------------------------- stimulus

	function automatic seg_req_t rand_req(input op_t o);
		seg_req_t r;
		r.op = o;
		r.data_byte = 8'($urandom);
		r.last_byte = 1'($urandom);
		r.link_ready = 1'($urandom);
		r.fc_bs = 8'($urandom);
		r.fc_all = 1'($urandom);
		r.rid = $urandom;
		r.r29 = 1'($urandom);
		r.rlen = 4'($urandom_range(0, 8));
		r.rpl = {$urandom, $urandom};
		r.gap = 0;
		return r;
	endfunction

	// queues a request and advances the look-ahead state
	task automatic push_req(input seg_req_t r);
		void'(seg_step(gen_st, r, cfg_cur));
		if (no_gaps || burst_left > 0) begin
			r.gap = 0;
			if (burst_left > 0) burst_left--;
		end else begin
			r.gap = $urandom_range(0, 16);
			if ($urandom_range(0, 7) == 0) burst_left = $urandom_range(5, 30);
		end
		req_q.insert(req_q.size(), r);
		gen_items++;
	endtask

	task automatic push_load(input logic [7:0] d, input logic last);
		seg_req_t r;
		r = rand_req(OP_LOAD);
		r.data_byte = d;
		r.last_byte = last;
		push_req(r);
	endtask

	task automatic push_send(input logic link);
		seg_req_t r;
		r = rand_req(OP_SEND);
		r.link_ready = link;
		push_req(r);
	endtask

	task automatic push_flow(input logic [7:0] bs, input logic all);
		seg_req_t r;
		r = rand_req(OP_FLOW);
		r.fc_bs = bs;
		r.fc_all = all;
		push_req(r);
	endtask

	// receipt echoing the last frame; a nonzero flaw breaks it in one way
	task automatic push_echo(input int flaw);
		seg_req_t r;
		int       k;
		r = rand_req(OP_RCPT);
		r.rid = cfg_cur.id;
		r.r29 = cfg_cur.is29;
		r.rlen = gen_st.last_len;
		// bytes past the length stay random, they must be ignored
		for (k = 0; k < r.rlen; k++) r.rpl[8*k +: 8] = gen_st.last_frame[8*k +: 8];
		case (flaw)
			1: if (r.rlen > 0) r.rpl[$urandom_range(0, 8 * r.rlen - 1)] ^= 1'b1;
				else r.rlen = 4'd1;
			2: r.rlen = (r.rlen == 8) ? 4'd0 : r.rlen + 4'd1;
			3: r.rid[$urandom_range(0, 31)] ^= 1'b1;
			4: r.r29 = ~r.r29;
			5: r.rpl[8*gen_st.m_ext +: 8] = {PCI_FC, 4'($urandom)};
			default: ;
		endcase
		push_req(r);
	endtask

	// one message loaded and then sent under flow control, receipts mostly clean
	task automatic gen_message(input int len);
		int guard;
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 24) == 0) push_send(1'b1);
			push_load(8'($urandom), i == len - 1);
		end
		guard = 0;
		while (gen_st.done_cnt < gen_st.total && guard < 2000) begin
			guard++;
			if (!(gen_st.budget > 0 || gen_st.unlimited || gen_st.done_cnt == 0)) begin
				if ($urandom_range(0, 3) == 0) push_flow(8'($urandom), 1'($urandom));
				else push_flow(8'($urandom_range(0, 4)), $urandom_range(0, 5) == 0);
			end
			push_send($urandom_range(0, 9) != 0);
			if (gen_st.in_flight && $urandom_range(0, 4) != 0)
				push_echo(($urandom_range(0, 4) == 0) ? $urandom_range(1, 5) : 0);
		end
		if ($urandom_range(0, 2) == 0) push_send(1'b1);
		if (gen_st.in_flight) push_echo(0);
	endtask

	task automatic gen_random(input int n_items);
		int stop_at;
		int pick;
		int len;
		stop_at = gen_items + n_items;
		while (gen_items < stop_at) begin
			if ($urandom_range(0, 9) == 0) begin
				// noise request of any kind
				push_req(rand_req(op_t'($urandom_range(0, 3))));
			end else begin
				pick = $urandom_range(0, 9);
				if (pick < 6) len = $urandom_range(1, 14);
				else if (pick < 9) len = $urandom_range(15, 80);
				else len = $urandom_range(81, 300);
				// keep the phase close to its share of requests
				if (len > stop_at - gen_items) len = stop_at - gen_items;
				gen_message(len);
			end
		end
	endtask

	// ---------------------------------------------------------------- configuration

	task automatic wait_idle();
		wait (req_q.size() == 0 && frame_exp_q.size() == 0 && !start);
		repeat (12) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [31:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_config(input seg_cfg_t c);
		wait_idle();
		write_reg(CFG_ID, c.id);
		write_reg(CFG_29, 32'(c.is29));
		write_reg(CFG_EXT, 32'(c.ext));
		write_reg(CFG_ADDR, 32'(c.addr));
		write_reg(CFG_PAD, 32'(c.pad));
		cfg_cur = c;
	endtask

	// ---------------------------------------------------------------- driver

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			hold_cnt <= 0;
		end else begin
			// request taken at this edge: predict its result now
			if (start && !busy)
				frame_exp_q.insert(frame_exp_q.size(), seg_step(dut_st, cur_req, cfg_cur));
			// a request the block has not taken yet stays on the ports
			if (!(start && busy)) begin
				if (req_q.size() == 0) begin
					start <= 1'b0;
				end else if (hold_cnt < req_q[0].gap) begin
					start <= 1'b0;
					hold_cnt <= hold_cnt + 1;
				end else begin
					cur_req = req_q.pop_front();
					hold_cnt <= 0;
					start <= 1'b1;
					op <= cur_req.op;
					data_byte <= cur_req.data_byte;
					last_byte <= cur_req.last_byte;
					link_ready <= cur_req.link_ready;
					fc_block_size <= cur_req.fc_bs;
					fc_send_all <= cur_req.fc_all;
					rx_identifier <= cur_req.rid;
					rx_is_29bit <= cur_req.r29;
					rx_length <= cur_req.rlen;
					rx_payload <= cur_req.rpl;
				end
			end
		end
	end

	// ---------------------------------------------------------------- monitor

	always @(posedge clk) begin
		seg_res_t got;
		seg_res_t want;
		if (arst_n && done) begin
			got = seg_res_t'({status, frame_bytes, frame_length, frame_number,
				tx_confirm, message_finished, tx_ready});
			if (frame_exp_q.size() == 0) begin
				n_errors++;
				if (n_errors <= 10) $display("result with no request pending: status %0d", status);
			end else begin
				want = frame_exp_q.pop_front();
				n_results++;
				if (got.flen != 0) n_frames++;
				if (got.ind) n_ind++;
				if (got !== want) begin
					n_errors++;
					if (n_errors <= 10)
						$display({"mismatch at result %0d: status %0d/%0d bytes %h/%h len %0d/%0d",
							" num %0d/%0d ind %0b/%0b fin %0b/%0b rdy %0b/%0b (expected/actual)"},
							n_results, want.status, got.status, want.fbytes, got.fbytes,
							want.flen, got.flen, want.fnum, got.fnum, want.ind, got.ind,
							want.fin, got.fin, want.rdy, got.rdy);
				end
			end
		end
	end

	// watchdog on cycles with no traffic at all
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || cfg_valid) begin
			quiet_cnt <= 0;
		end else if (quiet_cnt >= WATCHDOG_LIMIT) begin
			$display("watchdog: no traffic for %0d cycles", WATCHDOG_LIMIT);
			$display("*** FAILED ***");
			$finish;
		end else begin
			quiet_cnt <= quiet_cnt + 1;
		end
	end

	// ---------------------------------------------------------------- test sequence

	initial begin
		clear_state(gen_st);
		clear_state(dut_st);
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed part, registers at their reset values
		push_send(1'b1);                // nothing loaded
		push_req(rand_req(OP_RCPT));    // nothing in flight
		push_load(8'hFF, 1'b1);         // one-byte single frame
		push_send(1'b0);                // bus refuses
		push_send(1'b1);
		push_echo(5);                   // looks like flow control
		push_echo(1);                   // corrupted byte
		push_echo(0);                   // completes the message
		push_send(1'b1);                // all frames already sent
		for (int i = 0; i < 8; i++) push_load((i % 2 == 0) ? 8'h00 : 8'hFF, i == 7);
		push_send(1'b1);                // first frame
		push_send(1'b1);                // no flow-control budget after the first frame
		push_flow(8'd1, 1'b0);
		push_send(1'b1);
		push_echo(0);
		push_echo(0);                   // second echo finds nothing in flight
		push_flow(8'hFF, 1'b1);

		// random phases over a range of settings, extremes first
		set_config('{id: 32'hFFFF_FFFF, is29: 1'b1, ext: 1'b1, addr: 8'hFF, pad: 1'b1});
		gen_random(110);
		set_config('{id: 32'h0, is29: 1'b0, ext: 1'b0, addr: 8'h00, pad: 1'b1});
		gen_random(110);
		set_config('{id: $urandom, is29: 1'b1, ext: 1'b1, addr: 8'h00, pad: 1'b0});
		gen_random(110);
		set_config('{id: $urandom, is29: 1'b0, ext: 1'b0, addr: 8'($urandom), pad: 1'b0});
		gen_random(110);
		set_config('{id: $urandom, is29: 1'($urandom), ext: 1'b1, addr: 8'($urandom),
			pad: 1'b1});
		gen_random(110);

		// a long message sent in full, back to back
		set_config('{id: $urandom, is29: 1'b0, ext: 1'b1, addr: 8'($urandom), pad: 1'b1});
		no_gaps = 1'b1;
		for (int i = 0; i < LONG_MSG; i++) push_load(8'($urandom), i == LONG_MSG - 1);
		push_flow(8'h00, 1'b1);
		while (gen_st.done_cnt < gen_st.total) begin
			push_send(1'b1);
			push_echo(0);
		end
		no_gaps = 1'b0;

		// drain and let the last result settle
		wait (req_q.size() == 0 && frame_exp_q.size() == 0 && !start);
		repeat (20) @(posedge clk);
		if (frame_exp_q.size() != 0) n_errors++;
		$display("run covered %0d requests over 7 settings, %0d results checked",
			gen_items, n_results);
		$display("frames sent %0d, messages completed by receipt %0d, errors %0d",
			n_frames, n_ind, n_errors);
		if (n_errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end
endmodule
